@@ rtl/core/hbrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbrt_pkg
// Shared sizes, codes and control structs of the hashed bucket record table.
// ----------------------------------------------------------------------------
package hbrt_pkg;

    localparam int BUCKETS            = 32;
    localparam int RECORDS_PER_BUCKET = 16;
    localparam int TOTAL_SLOTS        = BUCKETS * RECORDS_PER_BUCKET;
    localparam int B_BITS             = $clog2(BUCKETS);
    localparam int S_BITS             = $clog2(RECORDS_PER_BUCKET);
    localparam int ADDR_W             = B_BITS + S_BITS;
    localparam int COUNT_W            = 10;

    localparam logic [1:0] ACT_FIND   = 2'd0;
    localparam logic [1:0] ACT_PLACE  = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_MISS  = 3'd1;
    localparam logic [2:0] ST_FREE  = 3'd2;
    localparam logic [2:0] ST_EVICT = 3'd3;
    localparam logic [2:0] ST_ZERO  = 3'd4;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] rank;
        logic [31:0] loc;
    } t_rec;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WR0,
        S_WR1,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic wr0;
        logic wr1;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic trivial;
        logic scan_end;
        logic wr_any;
        logic wr_two;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ rtl/core/hbrt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbrt_ctrl
// Sequencer: clear sweep, bucket scan, write-back and result strobe.
// ----------------------------------------------------------------------------
module hbrt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire hbrt_pkg::t_dp_stat i_stat,
    output hbrt_pkg::t_dp_cmd      o_cmd,
    output logic                   busy,
    output logic                   o_valid
);
    import hbrt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = i_stat.trivial ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    if (!i_stat.wr_any)     n_state = S_DONE;
                    else if (i_stat.wr_two) n_state = S_WR0;
                    else                    n_state = S_WR1;
                end
            end
            S_WR0:  n_state = S_WR1;
            S_WR1:  n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clear = 1'b1;
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_SCAN:  o_cmd.scan = 1'b1;
            S_WR0:   o_cmd.wr0  = 1'b1;
            S_WR1:   o_cmd.wr1  = 1'b1;
            S_DONE:  o_valid    = 1'b1;
            default: o_cmd      = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/hbrt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbrt_dp
// Datapath: slot memory, scan pipeline, eviction tracking and result word.
// ----------------------------------------------------------------------------
module hbrt_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hbrt_pkg::t_dp_cmd  i_cmd,
    input  wire logic [1:0]         i_action,
    input  wire logic [31:0]        i_hash_key,
    input  wire logic [31:0]        i_rank,
    input  wire logic [31:0]        i_location,
    output hbrt_pkg::t_dp_stat      o_stat,
    output logic [2:0]              o_status,
    output logic [31:0]             o_found_rank,
    output logic [31:0]             o_found_location,
    output logic [31:0]             o_evicted_hash,
    output logic [hbrt_pkg::COUNT_W-1:0] o_entry_count
);
    import hbrt_pkg::*;

    t_rec mem [TOTAL_SLOTS];
    t_rec rdata;

    logic [ADDR_W-1:0] r_clr_idx;
    logic [1:0]        r_act;
    logic [31:0]       r_key, r_rk, r_loc;
    logic [S_BITS:0]   r_rd_idx;
    logic [S_BITS-1:0] r_dat_idx;
    logic              r_dv;
    logic [S_BITS-1:0] r_low_idx, r_mi;
    logic [31:0]       r_low_rank, r_low_hash;
    logic              r_matched;
    t_rec              r_prev;
    logic [S_BITS-1:0] r_wa0, r_wa1;
    t_rec              r_wd1;
    logic [2:0]        r_status;
    logic [31:0]       r_frank, r_floc, r_evict;
    logic [COUNT_W-1:0] r_count;

    logic [B_BITS-1:0] bucket;
    logic              last_slot;
    logic              scan_end, wr_any, wr_two, cnt_inc, cnt_dec, set_match;
    logic [2:0]        n_status;
    logic [31:0]       n_frank, n_floc, n_evict;
    logic [S_BITS-1:0] n_wa0, n_wa1, n_low_idx;
    logic [31:0]       n_low_rank, n_low_hash;
    t_rec              n_wd1;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    t_rec              wdata;

    assign bucket    = r_key[B_BITS-1:0];
    assign last_slot = (r_dat_idx == S_BITS'(RECORDS_PER_BUCKET - 1));

    // slot memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        rdata <= mem[{bucket, r_rd_idx[S_BITS-1:0]}];
        if (we) mem[waddr] <= wdata;
    end

    always_comb begin
        we    = i_cmd.clear | i_cmd.wr0 | i_cmd.wr1;
        waddr = r_clr_idx;
        wdata = '0;
        if (i_cmd.wr0) begin
            waddr = {bucket, r_wa0};
        end else if (i_cmd.wr1) begin
            waddr = {bucket, r_wa1};
            wdata = r_wd1;
        end
    end

    // slot evaluation on the word returned by the read
    always_comb begin
        scan_end   = 1'b0;
        wr_any     = 1'b0;
        wr_two     = 1'b0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        set_match  = 1'b0;
        n_status   = ST_MISS;
        n_frank    = '0;
        n_floc     = '0;
        n_evict    = '0;
        n_wa0      = r_dat_idx;
        n_wa1      = r_dat_idx;
        n_wd1      = '{hash: r_key, rank: r_rk, loc: r_loc};
        n_low_idx  = r_low_idx;
        n_low_rank = r_low_rank;
        n_low_hash = r_low_hash;
        if (r_dv) begin
            case (r_act)
                ACT_FIND: begin
                    if (rdata.hash == 32'd0) begin
                        scan_end = 1'b1;
                    end else if (rdata.hash == r_key) begin
                        scan_end = 1'b1;
                        n_status = ST_DONE;
                        n_frank  = rdata.rank;
                        n_floc   = rdata.loc;
                    end else if (last_slot) begin
                        scan_end = 1'b1;
                    end
                end
                ACT_PLACE: begin
                    if (rdata.hash == 32'd0) begin
                        scan_end = 1'b1;
                        wr_any   = 1'b1;
                        cnt_inc  = 1'b1;
                        n_status = ST_FREE;
                    end else if (rdata.hash == r_key) begin
                        scan_end = 1'b1;
                        wr_any   = 1'b1;
                        n_status = ST_DONE;
                    end else begin
                        if (r_dat_idx == '0 || rdata.rank < r_low_rank) begin
                            n_low_idx  = r_dat_idx;
                            n_low_rank = rdata.rank;
                            n_low_hash = rdata.hash;
                        end
                        if (last_slot) begin
                            scan_end = 1'b1;
                            wr_any   = 1'b1;
                            n_status = ST_EVICT;
                            n_wa1    = n_low_idx;
                            n_evict  = n_low_hash;
                        end
                    end
                end
                ACT_DELETE: begin
                    if (!r_matched) begin
                        if (rdata.hash == 32'd0) begin
                            scan_end = 1'b1;
                        end else if (rdata.hash == r_key) begin
                            set_match = 1'b1;
                            if (last_slot) begin
                                scan_end = 1'b1;
                                wr_any   = 1'b1;
                                cnt_dec  = 1'b1;
                                n_status = ST_DONE;
                                n_wd1    = '0;
                            end
                        end else if (last_slot) begin
                            scan_end = 1'b1;
                        end
                    end else if (rdata.hash == 32'd0 || last_slot) begin
                        scan_end = 1'b1;
                        wr_any   = 1'b1;
                        cnt_dec  = 1'b1;
                        n_status = ST_DONE;
                        n_wa1    = r_mi;
                        if (rdata.hash == 32'd0) begin
                            // last record is the previous slot
                            n_wa0 = r_dat_idx - S_BITS'(1);
                            if (n_wa0 == r_mi) begin
                                n_wd1 = '0;
                            end else begin
                                wr_two = 1'b1;
                                n_wd1  = r_prev;
                            end
                        end else begin
                            wr_two = 1'b1;
                            n_wd1  = rdata;
                        end
                    end
                end
                default: scan_end = 1'b1;
            endcase
        end
    end

    always_comb begin
        o_stat.clear_last = (r_clr_idx == ADDR_W'(TOTAL_SLOTS - 1));
        o_stat.trivial    = (i_hash_key == 32'd0) || (i_action == ACT_UNUSED);
        o_stat.scan_end   = scan_end;
        o_stat.wr_any     = wr_any;
        o_stat.wr_two     = wr_two;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_count   <= '0;
            r_dv      <= 1'b0;
            r_matched <= 1'b0;
            r_rd_idx  <= '0;
        end else begin
            if (i_cmd.clear) r_clr_idx <= r_clr_idx + ADDR_W'(1);
            if (i_cmd.load) begin
                r_rd_idx  <= '0;
                r_dv      <= 1'b0;
                r_matched <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_idx  <= r_rd_idx + (S_BITS+1)'(1);
                r_dv      <= !scan_end &&
                             (r_rd_idx < (S_BITS+1)'(RECORDS_PER_BUCKET));
                if (set_match) r_matched <= 1'b1;
            end
            if (i_cmd.scan && scan_end) begin
                if (cnt_inc) r_count <= r_count + COUNT_W'(1);
                else if (cnt_dec && r_count != '0) r_count <= r_count - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= i_action;
            r_key    <= i_hash_key;
            r_rk     <= i_rank;
            r_loc    <= i_location;
            r_status <= (i_hash_key == 32'd0) ? ST_ZERO : ST_MISS;
            r_frank  <= '0;
            r_floc   <= '0;
            r_evict  <= '0;
        end
        if (i_cmd.scan) begin
            r_dat_idx  <= r_rd_idx[S_BITS-1:0];
            r_low_idx  <= n_low_idx;
            r_low_rank <= n_low_rank;
            r_low_hash <= n_low_hash;
            if (r_dv) r_prev <= rdata;
            if (set_match) r_mi <= r_dat_idx;
            if (scan_end) begin
                r_status <= n_status;
                r_frank  <= n_frank;
                r_floc   <= n_floc;
                r_evict  <= n_evict;
                r_wa0    <= n_wa0;
                r_wa1    <= n_wa1;
                r_wd1    <= n_wd1;
            end
        end
    end

    assign o_status         = r_status;
    assign o_found_rank     = r_frank;
    assign o_found_location = r_floc;
    assign o_evicted_hash   = r_evict;
    assign o_entry_count    = r_count;

endmodule
`default_nettype wire

@@ rtl/core/hashed_bucket_record_table_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_bucket_record_table_top
// Set-associative record table with find, place and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with i_action, i_hash_key, i_rank and i_location; the word
//   is taken at a rising edge where start is high and busy is low.
//   One result word per command appears on the o_ ports for exactly one
//   cycle, marked by o_valid. The receiver cannot stall, so it must take
//   the word in that cycle.
//   Timing: a zero key or unknown action strobes in the cycle right after
//   the accept. Other commands scan the bucket slot by slot behind a
//   registered read of the slot memory, then write back up to two slots
//   before the strobe. One command is in flight at a time; busy stays high
//   until the cycle after the strobe.
//   Reset: after i_rst_n the block sweeps the 512-slot memory to free,
//   one slot a cycle with busy high, and the entry count starts at zero.
// ----------------------------------------------------------------------------
module hashed_bucket_record_table_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_hash_key,
    input  wire logic [31:0] i_rank,
    input  wire logic [31:0] i_location,
    output logic             busy,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [31:0]      o_found_rank,
    output logic [31:0]      o_found_location,
    output logic [31:0]      o_evicted_hash,
    output logic [9:0]       o_entry_count
);
    import hbrt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    hbrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    hbrt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_action),
        .i_hash_key       (i_hash_key),
        .i_rank           (i_rank),
        .i_location       (i_location),
        .o_stat           (stat),
        .o_status         (o_status),
        .o_found_rank     (o_found_rank),
        .o_found_location (o_found_location),
        .o_evicted_hash   (o_evicted_hash),
        .o_entry_count    (o_entry_count)
    );

endmodule
`default_nettype wire

@@ rtl/core/hbrt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbrt_checker
// Port-level checks of the command handshake and result strobe.
// ----------------------------------------------------------------------------
module hbrt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [2:0]  o_status,
    input wire logic [9:0]  o_entry_count
);
    import hbrt_pkg::*;

    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low after accept");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result word while idle");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_ZERO) && (o_entry_count <= 10'(TOTAL_SLOTS)))
        else $error("result field out of range");

endmodule

bind hashed_bucket_record_table_top hbrt_checker u_hbrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);
`default_nettype wire
